FILE: rtl/mcta_pkg.sv
// Shared constants and types for the multichannel trimmed-mean averager.
package mcta_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int CHANNEL_W    = 4;
	localparam int MV_W         = 12;
	localparam int QUOT_W       = 12;
	localparam int MV_SCALE     = 3300;
	localparam int MV_SHIFT     = 12;
	localparam int SAMPLE_MAX   = 4095;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 16;
	localparam int DEF_CHANNELS = 4;
	localparam int DEF_SAMPLES  = 16;

	typedef enum logic [5:0] {
		ST_ACC   = 6'b000001,
		ST_ISSUE = 6'b000010,
		ST_RD    = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

endpackage

FILE: rtl/mcta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/multichannel_trimmed_mean_adc_unit.sv
// Top level: per-channel trimmed-mean averager with millivolt scaling.
//
// Input stream (s_*): one 12-bit sample per beat, channels interleaved,
// channel 0 first; a frame is SAMPLES rows of CHANNELS samples.
// Output stream (m_*): after the last sample of a frame, CHANNELS beats in
// channel order, each {millivolts, channel}; m_tlast marks the last channel.
// Result = ((sum - max - min) / (SAMPLES-2)) * 3300 / 4096, truncated.
//
// Throughput: one sample per cycle inside a frame. Per-channel state sits in
// one RAM entry {sum, max, min}; a sample reads its entry on the accept edge
// and writes it back the next cycle. A back-to-back hit on the same entry
// (only with one channel) is forwarded from the write stage.
// Frame end: input stalls for the burst. Each result steps through read
// issue, read data, reciprocal multiply for the divide, scale multiply and
// output beat. The burst starts on the last sample's write-back; input
// resumes once the last channel's beat is taken.
// The first row of a frame ignores RAM contents, so no clearing is needed.
// Reset: counters and FSM return to idle; the RAM is not cleared.
// Receiver stall: the output beat holds until m_tready; nothing is lost.
module multichannel_trimmed_mean_adc_unit #(
	parameter int CHANNELS = mcta_pkg::DEF_CHANNELS,
	parameter int SAMPLES  = mcta_pkg::DEF_SAMPLES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mcta_pkg::IN_TDATA_W-1:0]  s_tdata,  // [11:0] sample, [15:12] zero
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mcta_pkg::OUT_TDATA_W-1:0] m_tdata,  // [3:0] channel, [15:4] millivolts
	output logic                             m_tlast   // last channel of the frame
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ROW_W   = $clog2(SAMPLES);
	localparam int SUM_W   = $clog2(SAMPLES * mcta_pkg::SAMPLE_MAX + 1);
	localparam int SW      = mcta_pkg::SAMPLE_W;
	localparam int ENTRY_W = SUM_W + 2 * SW;
	localparam int DIVISOR = (SAMPLES > 2) ? SAMPLES - 2 : 1;
	// floor(x / DIVISOR) == (x * RECIP) >> RECIP_SH for every x below 2**SUM_W
	localparam int RECIP_SH = SUM_W + $clog2(DIVISOR);
	localparam int RECIP_W  = SUM_W + 1;
	localparam int QPROD_W  = SUM_W + RECIP_W;
	localparam int MPROD_W  = 2 * mcta_pkg::QUOT_W;
	localparam longint RECIP_VAL =
		((longint'(1) << RECIP_SH) + longint'(DIVISOR - 1)) / longint'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
	localparam logic [CH_W-1:0]    LAST_CH  = CH_W'(CHANNELS - 1);
	localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(SAMPLES - 1);

	mcta_pkg::state_t state_q;

	// input side counters
	logic [CH_W-1:0]  pos_q;
	logic [ROW_W-1:0] row_q;
	logic             s_fire;
	logic             frame_end;

	// write-back stage
	logic               valid_s1;
	logic               first_s1;
	logic               last_s1;
	logic               fwd_s1;
	logic [CH_W-1:0]    pos_s1;
	logic [SW-1:0]      sample_s1;
	logic [ENTRY_W-1:0] fwd_data_s1;

	// RAM ports
	logic               ram_we;
	logic               ram_re;
	logic [CH_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	// read-modify-write datapath
	logic [ENTRY_W-1:0] old_entry;
	logic [SUM_W-1:0]   old_sum;
	logic [SW-1:0]      old_max;
	logic [SW-1:0]      old_min;
	logic [SUM_W-1:0]   new_sum;
	logic [SW-1:0]      new_max;
	logic [SW-1:0]      new_min;

	// output side
	logic [CH_W-1:0]                  out_ch_q;
	logic [SUM_W-1:0]                 trim_q;
	logic [mcta_pkg::QUOT_W-1:0]      quot_q;
	logic [mcta_pkg::OUT_TDATA_W-1:0] out_q;
	logic [SUM_W-1:0]                 trimmed;
	logic [QPROD_W-1:0]               quot_prod;
	logic [MPROD_W-1:0]               prod;
	logic [mcta_pkg::MV_W-1:0]        mv;

	// input handshake: hold off while the frame's last write is in flight
	assign s_tready  = (state_q == mcta_pkg::ST_ACC) && !(valid_s1 && last_s1);
	assign s_fire    = s_tvalid && s_tready;
	assign frame_end = (pos_q == LAST_CH) && (row_q == LAST_ROW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_fire;
			if (s_fire) begin
				if (pos_q == LAST_CH) begin
					pos_q <= '0;
					row_q <= frame_end ? '0 : row_q + 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// write-back stage payload; forward when the same entry is written this cycle
	always_ff @(posedge clk) begin
		if (s_fire) begin
			sample_s1   <= s_tdata[SW-1:0];
			pos_s1      <= pos_q;
			first_s1    <= (row_q == '0);
			last_s1     <= frame_end;
			fwd_s1      <= valid_s1 && (pos_s1 == pos_q);
			fwd_data_s1 <= ram_wdata;
		end
	end

	assign old_entry = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign old_sum   = old_entry[ENTRY_W-1 -: SUM_W];
	assign old_max   = old_entry[2*SW-1 -: SW];
	assign old_min   = old_entry[SW-1:0];

	always_comb begin
		if (first_s1) begin
			new_sum = SUM_W'(sample_s1);
			new_max = sample_s1;
			new_min = sample_s1;
		end else begin
			new_sum = old_sum + SUM_W'(sample_s1);
			new_max = (sample_s1 > old_max) ? sample_s1 : old_max;
			new_min = (sample_s1 < old_min) ? sample_s1 : old_min;
		end
	end

	assign ram_wdata = {new_sum, new_max, new_min};
	assign ram_we    = valid_s1;
	assign ram_re    = s_fire || (state_q == mcta_pkg::ST_ISSUE);
	assign ram_raddr = (state_q == mcta_pkg::ST_ISSUE) ? out_ch_q : pos_q;

	mcta_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_s1),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// frame-end datapath: trim, divide by reciprocal multiply, scale
	assign trimmed   = ram_rdata[ENTRY_W-1 -: SUM_W]
		- SUM_W'(ram_rdata[2*SW-1 -: SW]) - SUM_W'(ram_rdata[SW-1:0]);
	assign quot_prod = QPROD_W'(trim_q) * QPROD_W'(RECIP);
	assign prod      = MPROD_W'(quot_q) * MPROD_W'(mcta_pkg::MV_SCALE);
	assign mv        = prod[mcta_pkg::MV_SHIFT +: mcta_pkg::MV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mcta_pkg::ST_ACC;
			out_ch_q <= '0;
		end else begin
			case (state_q)
				mcta_pkg::ST_ACC: begin
					if (valid_s1 && last_s1) begin
						out_ch_q <= '0;
						state_q  <= mcta_pkg::ST_ISSUE;
					end
				end
				mcta_pkg::ST_ISSUE: begin
					state_q <= mcta_pkg::ST_RD;
				end
				mcta_pkg::ST_RD: begin
					state_q <= mcta_pkg::ST_DIV;
				end
				mcta_pkg::ST_DIV: begin
					state_q <= mcta_pkg::ST_MUL;
				end
				mcta_pkg::ST_MUL: begin
					state_q <= mcta_pkg::ST_OUT;
				end
				mcta_pkg::ST_OUT: begin
					if (m_tready) begin
						if (out_ch_q == LAST_CH) begin
							state_q <= mcta_pkg::ST_ACC;
						end else begin
							out_ch_q <= out_ch_q + 1'b1;
							state_q  <= mcta_pkg::ST_ISSUE;
						end
					end
				end
				default: begin
					state_q <= mcta_pkg::ST_ACC;
				end
			endcase
		end
	end

	// trimmed sum, quotient and output payload registers
	always_ff @(posedge clk) begin
		if (state_q == mcta_pkg::ST_RD) begin
			trim_q <= trimmed;
		end
		if (state_q == mcta_pkg::ST_DIV) begin
			quot_q <= quot_prod[RECIP_SH +: mcta_pkg::QUOT_W];
		end
		if (state_q == mcta_pkg::ST_MUL) begin
			out_q <= {mv, mcta_pkg::CHANNEL_W'(out_ch_q)};
		end
	end

	assign m_tvalid = (state_q == mcta_pkg::ST_OUT);
	assign m_tdata  = out_q;
	assign m_tlast  = m_tvalid && (out_ch_q == LAST_CH);

	// input and output phases never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during result burst");

	// scaled result stays inside the converter range
	a_mv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:4] <= 12'd3299))
		else $error("millivolts out of range");

	// the frame's final write-back starts the burst
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcta_pkg::ST_ACC) && valid_s1 && last_s1
		|=> state_q == mcta_pkg::ST_ISSUE)
		else $error("burst did not start at frame end");

	// scaling always follows the divide step
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcta_pkg::ST_MUL) |-> $past(state_q == mcta_pkg::ST_DIV))
		else $error("scale step without divide");

endmodule

FILE: bench/multichannel_trimmed_mean_adc_unit_test.sv
// Testbench for the multichannel trimmed-mean averager: directed and random frames, scoreboarded.
`timescale 1ns / 1ps

module multichannel_trimmed_mean_adc_unit_test;

	localparam int SAMPLE_W     = mcta_pkg::SAMPLE_W;
	localparam int CHANNEL_W    = mcta_pkg::CHANNEL_W;
	localparam int MV_W         = mcta_pkg::MV_W;
	localparam int MV_SCALE     = mcta_pkg::MV_SCALE;
	localparam int MV_SHIFT     = mcta_pkg::MV_SHIFT;
	localparam int SAMPLE_MAX   = mcta_pkg::SAMPLE_MAX;
	localparam int IN_TDATA_W   = mcta_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W  = mcta_pkg::OUT_TDATA_W;
	localparam int CHANNELS     = mcta_pkg::DEF_CHANNELS;
	localparam int SAMPLES      = mcta_pkg::DEF_SAMPLES;
	localparam int TRIM_DIV     = (SAMPLES > 2) ? SAMPLES - 2 : 1;
	localparam int SUM_W        = 20;
	localparam int ITEMS_TARGET = 460;
	localparam int IDLE_PCT     = 26;
	// No idling on either side while this window of samples goes through.
	localparam int CALM_FROM    = 320;
	localparam int CALM_TO      = 448;
	// Receiver holds off once this many samples are in; the frame end lands
	// inside the hold, so the burst backs up and the input stalls.
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// Directed frame shapes.
	typedef enum logic [1:0] {
		PAT_LEVEL,  // every sample of a channel equals its level
		PAT_SPIKE,  // level, except one full-scale and one zero sample, both trimmed
		PAT_SWING,  // rows swing between zero and full scale
		PAT_WALK    // walking one and walking zero over all bit positions
	} frame_pattern_t;

	// Random frame styles.
	typedef enum logic [1:0] {
		STYLE_UNIFORM,  // any value
		STYLE_TIGHT,    // small noise around a per-channel level
		STYLE_EDGES     // mostly zero and full scale
	} noise_style_t;

	typedef struct packed {
		frame_pattern_t                     pattern;
		logic                               typed;  // mv below holds the answer
		logic [CHANNELS-1:0][SAMPLE_W-1:0]  level;
		logic [CHANNELS-1:0][MV_W-1:0]      mv;
	} frame_plan_t;

	typedef struct packed {
		logic [CHANNEL_W-1:0] channel;
		logic [MV_W-1:0]      millivolts;
		logic                 last;
	} average_t;

	localparam int DIRECTED_FRAMES = 4;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // [11:0] sample, [15:12] zero
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // [3:0] channel, [15:4] millivolts
	logic                   m_tlast;

	multichannel_trimmed_mean_adc_unit #(
		.CHANNELS(CHANNELS),
		.SAMPLES (SAMPLES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	// Own copy of the per-channel accumulators.
	logic [SUM_W-1:0]    acc_sum [CHANNELS];
	logic [SAMPLE_W-1:0] acc_max [CHANNELS];
	logic [SAMPLE_W-1:0] acc_min [CHANNELS];
	int                  row_cnt;
	int                  chan_pos;
	logic [MV_W-1:0]     frame_mv [CHANNELS];

	average_t pending_averages[$];
	frame_plan_t directed_frames [DIRECTED_FRAMES];
	logic                          typed_frame;
	logic [CHANNELS-1:0][MV_W-1:0] typed_mv;

	int samples_taken;
	int mismatches;
	int cycles;

	function automatic bit no_idle();
		return samples_taken >= CALM_FROM && samples_taken < CALM_TO;
	endfunction

	function automatic void clear_frame();
		int c;
		for (c = 0; c < CHANNELS; c++) begin
			acc_sum[c] = '0;
			acc_max[c] = '0;
			acc_min[c] = SAMPLE_W'(SAMPLE_MAX);
		end
		row_cnt  = 0;
		chan_pos = 0;
	endfunction

	// Folds one sample in; on the frame's last sample fills frame_mv and returns 1.
	function automatic bit fold_sample(logic [SAMPLE_W-1:0] value);
		logic [SUM_W-1:0] trimmed;
		logic [31:0]      scaled;
		int               c;
		acc_sum[chan_pos] = acc_sum[chan_pos] + SUM_W'(value);
		if (value > acc_max[chan_pos])
			acc_max[chan_pos] = value;
		if (value < acc_min[chan_pos])
			acc_min[chan_pos] = value;
		chan_pos++;
		if (chan_pos == CHANNELS) begin
			chan_pos = 0;
			row_cnt++;
		end
		if (row_cnt < SAMPLES)
			return 1'b0;
		for (c = 0; c < CHANNELS; c++) begin
			// max and min both went into the sum, so this never wraps
			trimmed     = acc_sum[c] - SUM_W'(acc_max[c]) - SUM_W'(acc_min[c]);
			scaled      = ((32'(trimmed) / TRIM_DIV) * MV_SCALE) >> MV_SHIFT;
			frame_mv[c] = scaled[MV_W-1:0];
		end
		clear_frame();
		return 1'b1;
	endfunction

	function automatic logic [SAMPLE_W-1:0] plan_sample(frame_plan_t plan, int row, int ch);
		logic [SAMPLE_W-1:0] one_hot;
		one_hot = SAMPLE_W'(1) << ((row + 3 * ch) % SAMPLE_W);
		case (plan.pattern)
			PAT_LEVEL: return plan.level[ch];
			PAT_SPIKE: begin
				if (row == 5)
					return SAMPLE_W'(SAMPLE_MAX);
				if (row == 9)
					return '0;
				return plan.level[ch];
			end
			PAT_SWING: return ((row + ch) % 2) ? SAMPLE_W'(SAMPLE_MAX) : '0;
			default:   return (row % 2) ? ~one_hot : one_hot;
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] noisy_sample(noise_style_t style, int level);
		int v;
		case (style)
			STYLE_TIGHT: begin
				v = level + $urandom_range(30) - 15;
				if (v < 0)
					v = 0;
				if (v > SAMPLE_MAX)
					v = SAMPLE_MAX;
				return SAMPLE_W'(v);
			end
			STYLE_EDGES: begin
				case ($urandom_range(2))
					0:       return '0;
					1:       return SAMPLE_W'(SAMPLE_MAX);
					default: return SAMPLE_W'($urandom);
				endcase
			end
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Offers one sample, with random idle cycles ahead of it, and books the
	// expected averages once the beat is taken.
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		int c;
		while (!no_idle() && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			s_tdata  <= IN_TDATA_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - SAMPLE_W){1'b0}}, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		samples_taken++;
		if (fold_sample(value)) begin
			for (c = 0; c < CHANNELS; c++)
				pending_averages.push_back(average_t'{
					channel:    CHANNEL_W'(c),
					millivolts: typed_frame ? typed_mv[c] : frame_mv[c],
					last:       (c == CHANNELS - 1)
				});
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog.
	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random backpressure, one long hold-off, and the scoreboard.
	initial begin
		int       hold_left;
		bit       hold_done;
		average_t want;
		hold_left = 0;
		hold_done = 0;
		m_tready  <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_averages.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected beat: ch %0d mv %0d last %0b",
							m_tdata[CHANNEL_W-1:0], m_tdata[CHANNEL_W +: MV_W], m_tlast);
				end else begin
					want = pending_averages.pop_front();
					if (m_tdata[CHANNEL_W-1:0] !== want.channel ||
					    m_tdata[CHANNEL_W +: MV_W] !== want.millivolts ||
					    m_tlast !== want.last) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("mismatch: expected ch %0d mv %0d last %0b, got ch %0d mv %0d last %0b",
								want.channel, want.millivolts, want.last,
								m_tdata[CHANNEL_W-1:0], m_tdata[CHANNEL_W +: MV_W], m_tlast);
					end
				end
			end
			if (!hold_done && samples_taken >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle() || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Stimulus.
	initial begin
		int           f;
		int           r;
		int           c;
		noise_style_t style;
		int           levels [CHANNELS];

		arst_n        <= 1'b0;
		s_tvalid      <= 1'b0;
		s_tdata       <= '0;
		samples_taken = 0;
		mismatches    = 0;
		typed_frame   = 1'b0;
		typed_mv      = '0;
		clear_frame();

		// level and mv lists run channel 3 down to channel 0
		directed_frames[0] = '{PAT_LEVEL, 1'b1,
			{12'd1024, 12'd2048, 12'd4095, 12'd0},
			{12'd825, 12'd1650, 12'd3299, 12'd0}};
		directed_frames[1] = '{PAT_SPIKE, 1'b1,
			{12'd4094, 12'd1, 12'd4000, 12'd100},
			{12'd3298, 12'd0, 12'd3222, 12'd80}};
		directed_frames[2] = '{PAT_SWING, 1'b0, '0, '0};
		directed_frames[3] = '{PAT_WALK, 1'b0, '0, '0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (f = 0; f < DIRECTED_FRAMES; f++) begin
			typed_frame = directed_frames[f].typed;
			typed_mv    = directed_frames[f].mv;
			for (r = 0; r < SAMPLES; r++)
				for (c = 0; c < CHANNELS; c++)
					send_sample(plan_sample(directed_frames[f], r, c));
		end
		typed_frame = 1'b0;

		// Whole random frames, stopping at the frame count nearest the item target.
		while (samples_taken + SAMPLES * CHANNELS / 2 < ITEMS_TARGET) begin
			style = noise_style_t'($urandom_range(STYLE_EDGES));
			for (c = 0; c < CHANNELS; c++)
				levels[c] = $urandom_range(SAMPLE_MAX);
			for (r = 0; r < SAMPLES; r++)
				for (c = 0; c < CHANNELS; c++)
					send_sample(noisy_sample(style, levels[c]));
		end
		s_tvalid <= 1'b0;

		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
